// ===== rtl/core/vba_pkg.sv =====
// Volume bar aggregator package: shared widths, lane control struct and codes.
// No dependencies.
package vba_pkg;
  localparam int WORD_W = 32;
  localparam int ACC_W  = 64;
  localparam int VOL_W  = 31;
  localparam int VCOL_W = 3;
  localparam int IDX_W  = 1;
  localparam logic [IDX_W-1:0] REG_VOLUME_COLUMN = 1'd0;
  localparam logic [IDX_W-1:0] REG_BAR_VOLUME    = 1'd1;

  typedef struct packed {
    logic start;
    logic zero_div;
  } lane_ctl_t;
endpackage

// ===== rtl/core/vba_if.sv =====
// Valid/ready channel interfaces for the volume bar aggregator.
// Depends on vba_pkg.
interface vba_row_if import vba_pkg::*; #(parameter int NUM_COLUMNS = 5) ();
  logic valid;
  logic ready;
  logic [NUM_COLUMNS-1:0][WORD_W-1:0] col;
  logic last_row;
  modport source (output valid, col, last_row, input ready);
  modport sink (input valid, col, last_row, output ready);
endinterface

interface vba_bar_if import vba_pkg::*; #(parameter int NUM_COLUMNS = 5) ();
  logic valid;
  logic ready;
  logic [NUM_COLUMNS-1:0][WORD_W-1:0] bar;
  logic end_of_batch;
  modport source (output valid, bar, end_of_batch, input ready);
  modport sink (input valid, bar, end_of_batch, output ready);
endinterface

interface vba_cfg_if import vba_pkg::*; ();
  logic valid;
  logic ready;
  logic [IDX_W-1:0] index;
  logic [WORD_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/vba_lane.sv =====
// One column lane: Q32.32 accumulator, multiply stage and restoring divider.
// Depends on vba_pkg.
module vba_lane import vba_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic                     acc_en,
  input  logic signed [WORD_W-1:0] take,
  input  logic signed [WORD_W-1:0] value,
  input  lane_ctl_t                ctl,
  input  logic [WORD_W-1:0]        divisor,
  output logic                     done,
  output logic [WORD_W-1:0]        quotient
);
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] prod;
  logic                    prod_vld;
  logic [ACC_W-1:0]        num;
  logic [WORD_W:0]         rem;
  logic                    neg;
  logic                    busy;
  logic [6:0]              cnt;
  logic [WORD_W:0]         rem_sh;
  logic [WORD_W:0]         rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= acc_en;
    end
    prod <= ACC_W'(take) * ACC_W'(value);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + prod;
    end
  end

  assign rem_sh   = {rem[WORD_W-1:0], num[ACC_W-1]};
  assign rem_next = (rem_sh >= {1'b0, divisor}) ? rem_sh - {1'b0, divisor} : rem_sh;
  assign quotient = neg ? WORD_W'(-num) : num[WORD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= !ctl.zero_div;
      done <= ctl.zero_div;
      cnt  <= 7'd0;
      neg  <= acc[ACC_W-1];
      num  <= ctl.zero_div ? '0 : (acc[ACC_W-1] ? ACC_W'(-acc) : acc);
      rem  <= '0;
    end else if (busy) begin
      rem <= rem_next;
      num <= {num[ACC_W-2:0], rem_sh >= {1'b0, divisor}};
      cnt <= cnt + 7'd1;
      if (cnt == 7'(ACC_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else if (done) begin
      done <= 1'b0;
    end
  end
endmodule

// ===== rtl/core/volume_bar_aggregator_core.sv =====
// Volume bar aggregator top level: row splitting sequencer, column lanes, bar merge.
// Depends on vba_pkg, vba_if and vba_lane.
// Each row is split across the bars it touches; each bar it closes waits for the
// 64-step restoring divider that every lane runs at once, and then for bars.ready;
// padding bars follow after the last row. One row at a time.
module volume_bar_aggregator_core import vba_pkg::*; #(
  parameter int MAX_BARS    = 32,
  parameter int NUM_COLUMNS = 5
) (
  input  logic      clk,
  input  logic      rst,
  vba_row_if.sink   rows,
  vba_bar_if.source bars,
  vba_cfg_if.sink   cfg
);
  localparam int BC_W = $clog2(MAX_BARS + 1);
  localparam logic [2:0] S_IDLE = 3'd0, S_CHECK = 3'd1, S_SPLIT = 3'd2,
    S_ACC = 3'd3, S_DIV = 3'd4, S_OUT = 3'd5, S_LAST = 3'd6, S_PAD = 3'd7;

  logic [VCOL_W-1:0] volume_column;
  logic [VOL_W-1:0]  bar_volume;
  logic [2:0]        state;
  logic [2:0]        ret;
  logic [NUM_COLUMNS-1:0][WORD_W-1:0] vals;
  logic              last;
  logic [WORD_W-1:0] remain;
  logic [WORD_W-1:0] bar_fill;
  logic [WORD_W-1:0] take;
  logic [BC_W-1:0]   bars_emitted;
  logic [1:0]        wait_cnt;
  logic [VCOL_W-1:0] vc;
  logic [WORD_W-1:0] full;
  logic [WORD_W-1:0] room;
  logic              bars_open;
  logic              clear;
  logic              clear_next;
  logic              acc_en;
  logic              acc_en_next;
  logic              start_next;
  lane_ctl_t         ctl;
  logic [NUM_COLUMNS-1:0] done;
  logic [NUM_COLUMNS-1:0][WORD_W-1:0] quo;

  assign vc   = (volume_column >= VCOL_W'(NUM_COLUMNS)) ? VCOL_W'(NUM_COLUMNS - 1)
                                                       : volume_column;
  assign full = (bar_volume == '0) ? WORD_W'(1) : WORD_W'(bar_volume);
  assign room = full - bar_fill;
  assign bars_open  = (bars_emitted < BC_W'(MAX_BARS));
  assign cfg.ready  = 1'b1;
  assign rows.ready = (state == S_IDLE);

  assign start_next = !rst &&
    ((state == S_CHECK && bars_open && bar_fill >= full) ||
     (state == S_ACC && wait_cnt == 2'd2 && bar_fill >= full) ||
     (state == S_LAST && last && bars_open && bar_fill != '0));
  assign acc_en_next = !rst && state == S_SPLIT && remain != '0 && bars_open;
  assign clear_next  = rst || (state == S_DIV && done[0]) || (state == S_PAD && !bars_open);

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_column <= '0;
      bar_volume    <= VOL_W'(65536000);
    end else if (cfg.valid) begin
      if (cfg.index == REG_VOLUME_COLUMN) begin
        volume_column <= cfg.data[VCOL_W-1:0];
      end else begin
        bar_volume <= cfg.data[VOL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    clear  <= clear_next;
    acc_en <= acc_en_next;
    ctl    <= '{start: start_next, zero_div: 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bar_fill     <= '0;
      bars_emitted <= '0;
      bars.valid   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (rows.valid) begin
            vals   <= rows.col;
            last   <= rows.last_row;
            remain <= rows.col[vc][WORD_W-1] ? '0 : rows.col[vc];
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (start_next) begin
            ret   <= S_SPLIT;
            state <= S_DIV;
          end else begin
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          if (acc_en_next) begin
            take     <= (remain < room) ? remain : room;
            wait_cnt <= '0;
            state    <= S_ACC;
          end else begin
            state <= S_LAST;
          end
        end
        S_ACC: begin
          wait_cnt <= wait_cnt + 2'd1;
          if (wait_cnt == 2'd0) begin
            bar_fill <= bar_fill + take;
            remain   <= remain - take;
          end
          if (wait_cnt == 2'd2) begin
            if (start_next) begin
              ret   <= S_SPLIT;
              state <= S_DIV;
            end else begin
              state <= S_SPLIT;
            end
          end
        end
        S_DIV: begin
          if (done[0]) begin
            for (int i = 0; i < NUM_COLUMNS; i++) begin
              bars.bar[i] <= (VCOL_W'(i) == vc) ? bar_fill : quo[i];
            end
            bars.end_of_batch <= (bars_emitted == BC_W'(MAX_BARS - 1));
            bars.valid   <= 1'b1;
            bars_emitted <= bars_emitted + BC_W'(1);
            bar_fill     <= '0;
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          if (bars.ready) begin
            bars.valid <= 1'b0;
            state      <= ret;
          end
        end
        S_LAST: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (start_next) begin
            ret   <= S_LAST;
            state <= S_DIV;
          end else begin
            state <= S_PAD;
          end
        end
        S_PAD: begin
          if (bars_open) begin
            bars.bar          <= '0;
            bars.end_of_batch <= (bars_emitted == BC_W'(MAX_BARS - 1));
            bars.valid        <= 1'b1;
            bars_emitted      <= bars_emitted + BC_W'(1);
            ret               <= S_PAD;
            state             <= S_OUT;
          end else begin
            bars_emitted <= '0;
            bar_fill     <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_COLUMNS; g++) begin : g_lane
    vba_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .clear    (clear),
      .acc_en   (acc_en && VCOL_W'(g) != vc),
      .take     (take),
      .value    (vals[g]),
      .ctl      (ctl),
      .divisor  (bar_fill),
      .done     (done[g]),
      .quotient (quo[g])
    );
  end
endmodule

// ===== rtl/core/vba_checker.sv =====
// Port-level checker for volume_bar_aggregator_core, bound to the top level.
// Depends on volume_bar_aggregator_core through the bind.
module vba_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic end_of_batch
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("bar word dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("row taken while bar pending");
  a_eob: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && end_of_batch |=> !out_valid)
    else $error("bar after end of batch");
  a_one_row: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("row taken while row in flight");
endmodule

bind volume_bar_aggregator_core vba_checker u_vba_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (rows.valid),
  .in_ready     (rows.ready),
  .out_valid    (bars.valid),
  .out_ready    (bars.ready),
  .end_of_batch (bars.end_of_batch)
);

// ===== bench/volume_bar_aggregator_checker.sv =====
`timescale 1ns / 100ps
// Bar checker: watches the row, bar and config channels of the volume bar aggregator,
// predicts each bar from the accepted rows and compares. Depends on vba_pkg and vba_if.
module volume_bar_aggregator_checker import vba_pkg::*; #(
  parameter int MAX_BARS    = 32,
  parameter int NUM_COLUMNS = 5
) (
  input  logic clk,
  input  logic rst,
  vba_row_if   rows,
  vba_bar_if   bars,
  vba_cfg_if   cfg,
  output int   errors,
  output int   pending
);
  typedef struct {
    logic [NUM_COLUMNS-1:0][WORD_W-1:0] col;
    logic eob;
  } bar_word_t;

  bar_word_t bar_q[$];
  logic [VCOL_W-1:0] vol_col_reg;
  logic [VOL_W-1:0] bar_vol_reg;
  longint wsum[NUM_COLUMNS];
  longint fill;
  int emitted;

  function automatic int active_vol_col();
    return (vol_col_reg < NUM_COLUMNS) ? int'(vol_col_reg) : NUM_COLUMNS - 1;
  endfunction

  function automatic void close_bar();
    bar_word_t b;
    int vc;
    longint q;
    vc = active_vol_col();
    for (int i = 0; i < NUM_COLUMNS; i++) begin
      if (i == vc) begin
        b.col[i] = fill[31:0];
      end else if (fill == 0) begin
        b.col[i] = '0;
      end else begin
        q = wsum[i] / fill;
        b.col[i] = q[31:0];
      end
    end
    b.eob = (emitted == MAX_BARS - 1);
    bar_q.push_back(b);
    emitted++;
    for (int i = 0; i < NUM_COLUMNS; i++) wsum[i] = 0;
    fill = 0;
  endfunction

  function automatic void pad_bar();
    bar_word_t b;
    b.col = '0;
    b.eob = (emitted == MAX_BARS - 1);
    bar_q.push_back(b);
    emitted++;
  endfunction

  function automatic void aggregate_row(logic [NUM_COLUMNS-1:0][WORD_W-1:0] c, logic last);
    longint vals[NUM_COLUMNS];
    longint full, v, room, take;
    int vc;
    vc = active_vol_col();
    full = (bar_vol_reg == 0) ? 1 : longint'(bar_vol_reg);
    for (int i = 0; i < NUM_COLUMNS; i++) vals[i] = longint'(signed'(c[i]));
    v = (vals[vc] < 0) ? 0 : vals[vc];
    if (emitted < MAX_BARS && fill >= full) close_bar();
    while (v > 0 && emitted < MAX_BARS) begin
      room = full - fill;
      take = (v < room) ? v : room;
      for (int i = 0; i < NUM_COLUMNS; i++)
        if (i != vc) wsum[i] += take * vals[i];
      fill += take;
      v -= take;
      if (fill >= full) close_bar();
    end
    if (last) begin
      if (emitted < MAX_BARS && fill != 0) close_bar();
      while (emitted < MAX_BARS) pad_bar();
      for (int i = 0; i < NUM_COLUMNS; i++) wsum[i] = 0;
      fill = 0;
      emitted = 0;
    end
  endfunction

  always @(posedge clk) begin
    bar_word_t exp_bar;
    bit bad;
    if (rst) begin
      vol_col_reg = '0;
      bar_vol_reg = 31'd65536000;
      for (int i = 0; i < NUM_COLUMNS; i++) wsum[i] = 0;
      fill = 0;
      emitted = 0;
      bar_q.delete();
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_VOLUME_COLUMN) vol_col_reg = cfg.data[VCOL_W-1:0];
        else if (cfg.index == REG_BAR_VOLUME) bar_vol_reg = cfg.data[VOL_W-1:0];
      end
      if (rows.valid && rows.ready) aggregate_row(rows.col, rows.last_row);
      if (bars.valid && bars.ready) begin
        if (bar_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: unexpected bar word", $realtime);
        end else begin
          exp_bar = bar_q.pop_front();
          bad = (exp_bar.eob !== bars.end_of_batch);
          for (int i = 0; i < NUM_COLUMNS; i++)
            if (exp_bar.col[i] !== bars.bar[i]) bad = 1;
          if (bad) begin
            errors++;
            if (errors <= 10)
              $display("%0t: bar mismatch expected %h eob %b, got %h eob %b", $realtime,
                       exp_bar.col, exp_bar.eob, bars.bar, bars.end_of_batch);
          end
        end
      end
    end
    pending = bar_q.size();
  end
endmodule

// ===== bench/volume_bar_aggregator_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for volume_bar_aggregator_core: drives rows and register writes under
// varying idle patterns, gives the verdict. Depends on vba_pkg, vba_if, the core and the checker.
module volume_bar_aggregator_core_tb;
  import vba_pkg::*;
  localparam int NCOL = 5;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN = 300;

  logic clk = 0;
  logic rst = 1;
  int errors, pending;
  int sidle = 0, rstall = 0;
  int quiet = 0;

  vba_row_if #(NCOL) rows_if();
  vba_bar_if #(NCOL) bars_if();
  vba_cfg_if cfg_if();

  volume_bar_aggregator_core #(.MAX_BARS(32), .NUM_COLUMNS(NCOL)) dut (
    .clk(clk), .rst(rst), .rows(rows_if), .bars(bars_if), .cfg(cfg_if)
  );

  volume_bar_aggregator_checker #(.MAX_BARS(32), .NUM_COLUMNS(NCOL)) checker_i (
    .clk(clk), .rst(rst), .rows(rows_if), .bars(bars_if), .cfg(cfg_if),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) bars_if.ready <= ($urandom_range(99) >= rstall);

  always @(posedge clk) begin
    if (rst || (rows_if.valid && rows_if.ready) || (bars_if.valid && bars_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] value);
    cfg_if.valid = 1;
    cfg_if.index = idx;
    cfg_if.data = value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 0;
  endtask

  task automatic send_row(logic [NCOL-1:0][WORD_W-1:0] c, logic last);
    while ($urandom_range(99) < sidle) begin
      rows_if.valid = 0;
      @(negedge clk);
    end
    rows_if.valid = 1;
    rows_if.col = c;
    rows_if.last_row = last;
    do @(posedge clk); while (!rows_if.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    rows_if.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic set_mode(int mode);
    case (mode % 4)
      0: begin sidle = 0; rstall = 0; end
      1: begin sidle = 53; rstall = 0; end
      2: begin sidle = 0; rstall = 53; end
      default: begin sidle = 21; rstall = 21; end
    endcase
  endtask

  function automatic logic [NCOL-1:0][WORD_W-1:0] random_row(int vc, longint bv);
    logic [NCOL-1:0][WORD_W-1:0] c;
    longint hi;
    for (int i = 0; i < NCOL; i++) c[i] = $urandom;
    hi = 2 * bv;
    if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
    if ($urandom_range(99) >= 15) begin
      if ($urandom_range(3) == 0) c[vc] = $urandom_range(0, bv > 64 ? 32'd64 : 32'(bv));
      else c[vc] = $urandom_range(0, 32'(hi));
    end
    return c;
  endfunction

  task automatic random_rows(int n, int vc, longint bv, bit leave_open);
    int left;
    left = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      left--;
      send_row(random_row(vc, bv), (left == 0) || (k == n - 1 && !leave_open));
      if (left == 0) left = $urandom_range(1, 8);
    end
  endtask

  initial begin
    logic [NCOL-1:0][WORD_W-1:0] c;
    longint bv_list[7] = '{1, 64'h7FFF_FFFF, 0, 65536, 40, 65536000, 3000};
    int vc_list[7] = '{1, 2, 5, 3, 7, 4, 0};
    longint bv;
    int vc;

    rows_if.valid = 0;
    rows_if.col = '0;
    rows_if.last_row = 0;
    cfg_if.valid = 0;
    cfg_if.index = REG_VOLUME_COLUMN;
    cfg_if.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    write_reg(REG_VOLUME_COLUMN, 32'd0);
    write_reg(REG_BAR_VOLUME, 32'd65536000);
    c = {5{32'h7FFF_FFFF}}; c[0] = 32'd500 << 16; send_row(c, 0);
    c = {5{32'h8000_0000}}; c[0] = 32'd700 << 16; send_row(c, 0);
    c = {$urandom, $urandom, $urandom, $urandom, 32'h8000_0000}; send_row(c, 0);
    c = {$urandom, $urandom, $urandom, $urandom, 32'h0}; send_row(c, 0);
    c = {32'hFFFF_FFFF, 32'h1, 32'h0, 32'h8000_0001, 32'd300 << 16}; send_row(c, 1);
    c = {$urandom, $urandom, $urandom, $urandom, 32'h0}; send_row(c, 1);
    c = {32'h1234_5678, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    send_row(c, 0);
    c = {$urandom, $urandom, $urandom, $urandom, 32'd500 << 16}; send_row(c, 0);
    c = {$urandom, $urandom, $urandom, $urandom, 32'd100 << 16}; send_row(c, 1);
    c = {$urandom, $urandom, $urandom, $urandom, 32'd1500 << 16}; send_row(c, 0);
    drain();
    write_reg(REG_BAR_VOLUME, 32'd65536000 >> 2);
    c = {$urandom, $urandom, $urandom, $urandom, 32'd10 << 16}; send_row(c, 1);
    drain();

    for (int p = 0; p < 7; p++) begin
      bv = bv_list[p];
      vc = vc_list[p];
      set_mode(p + 1);
      write_reg(REG_VOLUME_COLUMN, ($urandom & ~32'h7) | 32'(vc[VCOL_W-1:0]));
      write_reg(REG_BAR_VOLUME, {1'($urandom_range(1)), bv[VOL_W-1:0]});
      if (vc >= NCOL) vc = NCOL - 1;
      if (bv == 0) bv = 1;
      random_rows(15, vc, bv, p % 3 == 1);
      drain();
    end

    set_mode(0);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/vba_pkg.sv
rtl/core/vba_if.sv
rtl/core/vba_lane.sv
rtl/core/volume_bar_aggregator_core.sv
rtl/core/vba_checker.sv
bench/volume_bar_aggregator_checker.sv
bench/volume_bar_aggregator_core_tb.sv
